FILE: rtl/core/multi_channel_debounce_edge_width_core_defines.svh
// Assertion macros shared by the debouncer checker.
// No dependencies; take in by `include where assertions are written.
`ifndef MULTI_CHANNEL_DEBOUNCE_EDGE_WIDTH_CORE_DEFINES_SVH
`define MULTI_CHANNEL_DEBOUNCE_EDGE_WIDTH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MCDEW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MCDEW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/mcdew_pkg.sv
// Package of the multi-channel debouncer: sizes, register codes, reset
// values and the structs passed between lanes, read stage and top level.
package mcdew_pkg;

   localparam int NUM_GROUPS_DEF         = 6;
   localparam int CHANNELS_PER_GROUP_DEF = 8;
   localparam int MAX_WIDTH_DEF          = 65535;

   localparam int SLOT_STRIDE    = 8;   // bit 8*group+channel in every vector
   localparam int SLOT_GROUPS    = 8;   // groups addressable by a 3-bit field
   localparam int REG_GROUPS     = 6;   // groups that own a channel-count register
   localparam int RAW_BITS       = 48;
   localparam int FUNC_BITS      = 2;
   localparam int GROUP_BITS     = 3;
   localparam int CHANNEL_BITS   = 3;
   localparam int COUNT_BITS     = 8;
   localparam int WIDTH_BITS     = 16;
   localparam int CHAN_CNT_BITS  = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 8;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_SAMPLE       = 2'd0,
      FUNC_READ_GROUP   = 2'd1,
      FUNC_READ_CHANNEL = 2'd2
   } func_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_TIME     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GROUP_ENABLE    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GROUP0_CHANNELS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GROUP5_CHANNELS = 3'd7;

   localparam logic [COUNT_BITS-1:0] FILTER_TIME_RST  = 8'd5;
   localparam logic [REG_GROUPS-1:0] GROUP_ENABLE_RST = 6'h3F;
   localparam logic [REG_GROUPS-1:0][CHAN_CNT_BITS-1:0] GROUP_CHANNELS_RST =
      {4'd4, 4'd6, 4'd6, 4'd8, 4'd8, 4'd2};

   typedef struct packed {
      logic                  level;
      logic                  rise;
      logic                  fall;
      logic [WIDTH_BITS-1:0] high_width;
      logic [WIDTH_BITS-1:0] low_width;
   } lane_stat_type;

   typedef struct packed {
      logic sample;
      logic raw;
      logic clear;
   } lane_ctl_type;

   typedef struct packed {
      logic                    group_rd;
      logic                    channel_rd;
      logic [GROUP_BITS-1:0]   group;
      logic [CHANNEL_BITS-1:0] channel;
   } read_req_type;

   typedef struct packed {
      logic [SLOT_STRIDE-1:0] level_bits;
      logic [SLOT_STRIDE-1:0] rising_bits;
      logic [SLOT_STRIDE-1:0] falling_bits;
      logic [WIDTH_BITS-1:0]  high_width;
      logic [WIDTH_BITS-1:0]  low_width;
   } rsp_word_type;

   typedef logic [SLOT_GROUPS-1:0][SLOT_STRIDE-1:0] slot_mask_type;
   typedef lane_stat_type [SLOT_GROUPS-1:0][SLOT_STRIDE-1:0] slot_stat_type;

endpackage

FILE: rtl/core/mcdew_if.sv
// Valid/ready channel interfaces of the multi-channel debouncer.
// Depends on mcdew_pkg for field widths.
interface mcdew_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [mcdew_pkg::FUNC_BITS-1:0]      func;
   logic [mcdew_pkg::RAW_BITS-1:0]       raw_levels;
   logic [mcdew_pkg::GROUP_BITS-1:0]     group;
   logic [mcdew_pkg::CHANNEL_BITS-1:0]   channel;

   modport source (output valid, func, raw_levels, group, channel, input ready);
   modport sink   (input valid, func, raw_levels, group, channel, output ready);
endinterface

interface mcdew_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mcdew_pkg::SLOT_STRIDE-1:0]   level_bits;
   logic [mcdew_pkg::SLOT_STRIDE-1:0]   rising_bits;
   logic [mcdew_pkg::SLOT_STRIDE-1:0]   falling_bits;
   logic [mcdew_pkg::WIDTH_BITS-1:0]    high_width;
   logic [mcdew_pkg::WIDTH_BITS-1:0]    low_width;

   modport source (output valid, level_bits, rising_bits, falling_bits, high_width,
                   low_width, input ready);
   modport sink   (input valid, level_bits, rising_bits, falling_bits, high_width,
                   low_width, output ready);
endinterface

FILE: rtl/core/mcdew_lane.sv
// One debounce lane: confirm counters, width counters, level and edge flags.
// Depends on mcdew_pkg.
module mcdew_lane #(
   parameter int MAX_WIDTH = mcdew_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mcdew_pkg::lane_ctl_type             ctl,
   input  logic [mcdew_pkg::COUNT_BITS-1:0]    filter_time,
   output mcdew_pkg::lane_stat_type            stat
);

   localparam logic [mcdew_pkg::WIDTH_BITS-1:0] WIDTH_MAX =
      mcdew_pkg::WIDTH_BITS'(MAX_WIDTH);

   logic                              level_ff, level_in;
   logic                              rise_ff, rise_in;
   logic                              fall_ff, fall_in;
   logic [mcdew_pkg::COUNT_BITS-1:0]  hc_ff, hc_in;
   logic [mcdew_pkg::COUNT_BITS-1:0]  lc_ff, lc_in;
   logic [mcdew_pkg::WIDTH_BITS-1:0]  hw_ff, hw_in;
   logic [mcdew_pkg::WIDTH_BITS-1:0]  lw_ff, lw_in;
   logic [mcdew_pkg::WIDTH_BITS-1:0]  hw_base, lw_base;

   // restart a width on the first sample of a level whose counter is clear
   assign hw_base = (hc_ff == '0) ? '0 : hw_ff;
   assign lw_base = (lc_ff == '0) ? '0 : lw_ff;

   always_comb begin
      level_in = level_ff;
      rise_in  = rise_ff;
      fall_in  = fall_ff;
      hc_in    = hc_ff;
      lc_in    = lc_ff;
      hw_in    = hw_ff;
      lw_in    = lw_ff;
      if (ctl.sample) begin
         if (ctl.raw) begin
            hw_in = (hw_base < WIDTH_MAX) ? hw_base + 1'b1 : hw_base;
            if (hc_ff < filter_time) begin
               hc_in = hc_ff + 1'b1;
            end else if (!level_ff) begin
               lc_in    = '0;
               level_in = 1'b1;
               rise_in  = 1'b1;
            end
         end else begin
            lw_in = (lw_base < WIDTH_MAX) ? lw_base + 1'b1 : lw_base;
            if (lc_ff < filter_time) begin
               lc_in = lc_ff + 1'b1;
            end else if (level_ff) begin
               hc_in    = '0;
               level_in = 1'b0;
               fall_in  = 1'b1;
            end
         end
      end
      if (ctl.clear) begin
         rise_in = 1'b0;
         fall_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         rise_ff  <= 1'b0;
         fall_ff  <= 1'b0;
         hc_ff    <= '0;
         lc_ff    <= '0;
         hw_ff    <= '0;
         lw_ff    <= '0;
      end else begin
         level_ff <= level_in;
         rise_ff  <= rise_in;
         fall_ff  <= fall_in;
         hc_ff    <= hc_in;
         lc_ff    <= lc_in;
         hw_ff    <= hw_in;
         lw_ff    <= lw_in;
      end
   end

   assign stat.level      = level_ff;
   assign stat.rise       = rise_ff;
   assign stat.fall       = fall_ff;
   assign stat.high_width = hw_ff;
   assign stat.low_width  = lw_ff;

endmodule

FILE: rtl/core/mcdew_merge.sv
// Read stage: gathers lane status into a result word, raises flag clears,
// and holds results in a two-word output buffer. Depends on mcdew_pkg, mcdew_if.
module mcdew_merge #(
   parameter int NUM_GROUPS         = mcdew_pkg::NUM_GROUPS_DEF,
   parameter int CHANNELS_PER_GROUP = mcdew_pkg::CHANNELS_PER_GROUP_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mcdew_pkg::read_req_type    rd,
   input  mcdew_pkg::slot_stat_type   stat,
   output mcdew_pkg::slot_mask_type   clr,
   output logic                       take_ok,
   mcdew_rsp_if.source                rsp_chan
);

   logic                    grp_ok, chan_ok, push, pop;
   mcdew_pkg::lane_stat_type sel;
   mcdew_pkg::rsp_word_type word;
   mcdew_pkg::rsp_word_type out_word_ff, out_word_in;
   mcdew_pkg::rsp_word_type skid_word_ff, skid_word_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    skid_valid_ff, skid_valid_in;

   assign grp_ok  = {1'b0, rd.group} < (mcdew_pkg::GROUP_BITS + 1)'(NUM_GROUPS);
   assign chan_ok = {1'b0, rd.channel} < (mcdew_pkg::CHANNEL_BITS + 1)'(CHANNELS_PER_GROUP);
   assign sel     = stat[rd.group][rd.channel];
   assign push    = rd.group_rd | rd.channel_rd;
   assign pop     = out_valid_ff & rsp_chan.ready;

   // build the word; out-of-range reads give an all-zero word
   always_comb begin
      word = '0;
      clr  = '0;
      if (rd.group_rd && grp_ok) begin
         for (int c = 0; c < mcdew_pkg::SLOT_STRIDE; c++) begin
            word.level_bits[c]   = stat[rd.group][c].level;
            word.rising_bits[c]  = stat[rd.group][c].rise;
            word.falling_bits[c] = stat[rd.group][c].fall;
         end
         clr[rd.group] = '1;
      end else if (rd.channel_rd && grp_ok && chan_ok) begin
         word.level_bits   = {{(mcdew_pkg::SLOT_STRIDE-1){1'b0}}, sel.level};
         word.rising_bits  = {{(mcdew_pkg::SLOT_STRIDE-1){1'b0}}, sel.rise};
         word.falling_bits = {{(mcdew_pkg::SLOT_STRIDE-1){1'b0}}, sel.fall};
         word.high_width   = sel.high_width;
         word.low_width    = sel.low_width;
         clr[rd.group][rd.channel] = 1'b1;
      end
   end

   // two-word buffer: the skid word drains first; no push while it is full
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_word_in  = word;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_word_in  = word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign take_ok               = !skid_valid_ff;
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.level_bits   = out_word_ff.level_bits;
   assign rsp_chan.rising_bits  = out_word_ff.rising_bits;
   assign rsp_chan.falling_bits = out_word_ff.falling_bits;
   assign rsp_chan.high_width   = out_word_ff.high_width;
   assign rsp_chan.low_width    = out_word_ff.low_width;

endmodule

FILE: rtl/core/multi_channel_debounce_edge_width_core.sv
// Multi-channel debouncer with sticky edge flags and level width counters.
// Depends on mcdew_pkg, mcdew_if, mcdew_lane and mcdew_merge.
//
// Up to 48 inputs sit in groups of eight; channel c of group g is bit 8*g+c
// of raw_levels. Request words may arrive back to back at one per cycle while
// req_chan.ready is high. A sample tick (func 0) updates all used channels of
// all enabled groups at once, one debounce lane per channel, and returns
// nothing. A group read (func 1) or channel read (func 2) returns one response
// word, built on the edge that accepts the request. The word goes into the
// output register, or into a skid register behind it while the output register
// still holds a word not yet taken; with the output side free it is visible in
// the cycle after acceptance. The flags it reports are cleared on that same
// edge, and the next word already sees them clear.
// The response side has a two-word buffer: req_chan.ready drops only when two
// responses are waiting, and then stays low until the consumer takes one. A
// read of a group or channel beyond the configured size returns an all-zero
// word and clears nothing. Configuration is written through csr_*, one register
// per cycle, only while no word is in flight; the user must ensure this, not the block.
module multi_channel_debounce_edge_width_core #(
   parameter int NUM_GROUPS         = mcdew_pkg::NUM_GROUPS_DEF,
   parameter int CHANNELS_PER_GROUP = mcdew_pkg::CHANNELS_PER_GROUP_DEF,
   parameter int MAX_WIDTH          = mcdew_pkg::MAX_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   mcdew_req_if.sink                             req_chan,
   mcdew_rsp_if.source                           rsp_chan,
   input  logic                                  csr_we,
   input  logic [mcdew_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mcdew_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   // only groups that both exist and own a channel-count register get lanes
   localparam int LANE_GROUPS =
      (NUM_GROUPS < mcdew_pkg::REG_GROUPS) ? NUM_GROUPS : mcdew_pkg::REG_GROUPS;

   logic [mcdew_pkg::COUNT_BITS-1:0]    filter_time_ff;
   logic [mcdew_pkg::REG_GROUPS-1:0]    group_enable_ff;
   logic [mcdew_pkg::REG_GROUPS-1:0][mcdew_pkg::CHAN_CNT_BITS-1:0] group_channels_ff;

   logic                      accept, tick, take_ok;
   mcdew_pkg::func_type       func;
   mcdew_pkg::read_req_type   rd;
   mcdew_pkg::slot_stat_type  stat;
   mcdew_pkg::slot_mask_type  clr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_time_ff    <= mcdew_pkg::FILTER_TIME_RST;
         group_enable_ff   <= mcdew_pkg::GROUP_ENABLE_RST;
         group_channels_ff <= mcdew_pkg::GROUP_CHANNELS_RST;
      end else if (csr_we) begin
         case (csr_index)
            mcdew_pkg::CSR_FILTER_TIME: begin
               filter_time_ff <= csr_wdata;
            end
            mcdew_pkg::CSR_GROUP_ENABLE: begin
               group_enable_ff <= csr_wdata[mcdew_pkg::REG_GROUPS-1:0];
            end
            default: begin
               if (csr_index inside {[mcdew_pkg::CSR_GROUP0_CHANNELS :
                                      mcdew_pkg::CSR_GROUP5_CHANNELS]}) begin
                  group_channels_ff[csr_index - mcdew_pkg::CSR_GROUP0_CHANNELS] <=
                     csr_wdata[mcdew_pkg::CHAN_CNT_BITS-1:0];
               end
            end
         endcase
      end
   end

   // hold off new words only while the response buffer is full
   assign req_chan.ready = take_ok;
   assign accept         = req_chan.valid & take_ok;
   assign func           = mcdew_pkg::func_type'(req_chan.func);

   // decode the function; the unused code is dropped without effect
   always_comb begin
      tick          = 1'b0;
      rd.group_rd   = 1'b0;
      rd.channel_rd = 1'b0;
      rd.group      = req_chan.group;
      rd.channel    = req_chan.channel;
      case (func)
         mcdew_pkg::FUNC_SAMPLE:       tick          = accept;
         mcdew_pkg::FUNC_READ_GROUP:   rd.group_rd   = accept;
         mcdew_pkg::FUNC_READ_CHANNEL: rd.channel_rd = accept;
         default: begin
            tick = 1'b0;
         end
      endcase
   end

   // lane array: one lane per used slot, absent slots read as zero
   for (genvar g = 0; g < mcdew_pkg::SLOT_GROUPS; g++) begin : g_grp
      for (genvar c = 0; c < mcdew_pkg::SLOT_STRIDE; c++) begin : g_chn
         if (g < LANE_GROUPS && c < CHANNELS_PER_GROUP) begin : g_lane
            mcdew_pkg::lane_ctl_type ctl;

            // advance a lane only in an enabled group and below its channel count
            assign ctl.sample = tick & group_enable_ff[g] &
               (mcdew_pkg::CHAN_CNT_BITS'(c) < group_channels_ff[g]);
            assign ctl.raw    = req_chan.raw_levels[g * mcdew_pkg::SLOT_STRIDE + c];
            assign ctl.clear  = clr[g][c];

            mcdew_lane #(
               .MAX_WIDTH (MAX_WIDTH)
            ) u_lane (
               .clock       (clock),
               .reset       (reset),
               .ctl         (ctl),
               .filter_time (filter_time_ff),
               .stat        (stat[g][c])
            );
         end else begin : g_none
            assign stat[g][c] = '0;
         end
      end
   end

   mcdew_merge #(
      .NUM_GROUPS         (NUM_GROUPS),
      .CHANNELS_PER_GROUP (CHANNELS_PER_GROUP)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .rd       (rd),
      .stat     (stat),
      .clr      (clr),
      .take_ok  (take_ok),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: rtl/core/mcdew_checker.sv
// Port-level checker for the multi-channel debouncer, bound to the top level.
// Depends on mcdew_pkg and the assertion macros header.
`include "multi_channel_debounce_edge_width_core_defines.svh"

module mcdew_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [mcdew_pkg::FUNC_BITS-1:0]     req_func,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [mcdew_pkg::SLOT_STRIDE-1:0]   level_bits,
   input logic [mcdew_pkg::SLOT_STRIDE-1:0]   rising_bits,
   input logic [mcdew_pkg::SLOT_STRIDE-1:0]   falling_bits,
   input logic [mcdew_pkg::WIDTH_BITS-1:0]    high_width,
   input logic [mcdew_pkg::WIDTH_BITS-1:0]    low_width
);

   logic read_taken;
   logic rsp_stall;
   logic width_set;
   logic upper_clear;
   logic [3*mcdew_pkg::SLOT_STRIDE+2*mcdew_pkg::WIDTH_BITS:0] rsp_snap;

   assign read_taken = req_valid && req_ready &&
      (req_func == mcdew_pkg::FUNC_READ_GROUP || req_func == mcdew_pkg::FUNC_READ_CHANNEL);
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_snap   = {rsp_valid, level_bits, rising_bits, falling_bits, high_width,
                        low_width};
   assign width_set  = rsp_valid && (high_width != '0 || low_width != '0);
   assign upper_clear = level_bits[mcdew_pkg::SLOT_STRIDE-1:1] == '0 &&
                        rising_bits[mcdew_pkg::SLOT_STRIDE-1:1] == '0 &&
                        falling_bits[mcdew_pkg::SLOT_STRIDE-1:1] == '0;

   // a stalled response word holds
   `MCDEW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_snap), "stalled word moved")

   // an accepted read shows a response on the next cycle
   `MCDEW_ASSERT_NEXT(a_read_rsp, clock, reset, read_taken, rsp_valid, "read gave no response")

   // the request side stalls only while responses are waiting
   `MCDEW_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready, rsp_valid, "stall with no response")

   // a word with widths comes from a channel read and so has no bit above bit 0 set
   `MCDEW_ASSERT_NOW(a_chan_shape, clock, reset, width_set, upper_clear, "channel word too wide")

endmodule

bind multi_channel_debounce_edge_width_core mcdew_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_func     (req_chan.func),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .level_bits   (rsp_chan.level_bits),
   .rising_bits  (rsp_chan.rising_bits),
   .falling_bits (rsp_chan.falling_bits),
   .high_width   (rsp_chan.high_width),
   .low_width    (rsp_chan.low_width)
);

FILE: sim/tb_top.sv
// Testbench of the multi-channel debouncer core: directed and random request
// words checked against an in-bench debounce predictor.
// Depends on mcdew_pkg, mcdew_if and multi_channel_debounce_edge_width_core.
module tb_top;

   // Unused request code: the block must swallow it without a response.
   localparam logic [mcdew_pkg::FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
   localparam int DRAIN_LIMIT   = 4000;  // cycles to wait for outstanding reads
   localparam int SETTLE_CYCLES = 4;     // response shows in the cycle after accept while the output side is free
   localparam int HOLD_SAMPLES  = 60;

   logic clock;
   logic reset;
   logic csr_we;
   logic [mcdew_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [mcdew_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   mcdew_req_if req_chan ();
   mcdew_rsp_if rsp_chan ();

   multi_channel_debounce_edge_width_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Idle percentages of the request and response sides; changed per phase.
   int send_idle_pct = 22;
   int recv_idle_pct = 55;
   int mismatch_count = 0;

   // Predictor copy of the registers.
   logic [mcdew_pkg::COUNT_BITS-1:0]    filt;
   logic [mcdew_pkg::REG_GROUPS-1:0]    grp_en;
   logic [mcdew_pkg::CHAN_CNT_BITS-1:0] grp_chans [mcdew_pkg::REG_GROUPS];

   // Predictor copy of the debounce state, one bit or entry per slot.
   logic [mcdew_pkg::RAW_BITS-1:0]   lvl;
   logic [mcdew_pkg::RAW_BITS-1:0]   rise_flag;
   logic [mcdew_pkg::RAW_BITS-1:0]   fall_flag;
   logic [mcdew_pkg::COUNT_BITS-1:0] hi_conf  [mcdew_pkg::RAW_BITS];
   logic [mcdew_pkg::COUNT_BITS-1:0] lo_conf  [mcdew_pkg::RAW_BITS];
   logic [mcdew_pkg::WIDTH_BITS-1:0] hi_width [mcdew_pkg::RAW_BITS];
   logic [mcdew_pkg::WIDTH_BITS-1:0] lo_width [mcdew_pkg::RAW_BITS];

   // Response words still owed by the block, oldest first.
   mcdew_pkg::rsp_word_type pending_status [$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [mcdew_pkg::RAW_BITS-1:0] rand48();
      return {16'($urandom), $urandom};
   endfunction

   // Bring registers and debounce state to their reset values.
   function automatic void clear_debounce_state();
      filt      = mcdew_pkg::FILTER_TIME_RST;
      grp_en    = mcdew_pkg::GROUP_ENABLE_RST;
      lvl       = '0;
      rise_flag = '0;
      fall_flag = '0;
      for (int g = 0; g < mcdew_pkg::REG_GROUPS; g++)
         grp_chans[g] = mcdew_pkg::GROUP_CHANNELS_RST[g];
      for (int s = 0; s < mcdew_pkg::RAW_BITS; s++) begin
         hi_conf[s]  = '0;
         lo_conf[s]  = '0;
         hi_width[s] = '0;
         lo_width[s] = '0;
      end
   endfunction

   function automatic void set_register(input logic [mcdew_pkg::CSR_INDEX_BITS-1:0] idx,
                                        input logic [mcdew_pkg::CSR_DATA_BITS-1:0] val);
      if (idx == mcdew_pkg::CSR_FILTER_TIME)
         filt = val;
      else if (idx == mcdew_pkg::CSR_GROUP_ENABLE)
         grp_en = val[mcdew_pkg::REG_GROUPS-1:0];
      else if (idx >= mcdew_pkg::CSR_GROUP0_CHANNELS && idx <= mcdew_pkg::CSR_GROUP5_CHANNELS)
         grp_chans[idx - mcdew_pkg::CSR_GROUP0_CHANNELS] = val[mcdew_pkg::CHAN_CNT_BITS-1:0];
   endfunction

   // One sample tick over every used channel of every enabled group.
   function automatic void debounce_tick(input logic [mcdew_pkg::RAW_BITS-1:0] raw);
      int n;
      int slot;
      for (int g = 0; g < mcdew_pkg::NUM_GROUPS_DEF; g++) begin
         if (!grp_en[g])
            continue;
         // Channel counts above the group size saturate.
         n = (grp_chans[g] > mcdew_pkg::CHANNELS_PER_GROUP_DEF)
            ? mcdew_pkg::CHANNELS_PER_GROUP_DEF : int'(grp_chans[g]);
         for (int c = 0; c < n; c++) begin
            slot = g * mcdew_pkg::SLOT_STRIDE + c;
            if (raw[slot]) begin
               // Restart the width on the first high after a low confirmation.
               if (hi_conf[slot] == 0)
                  hi_width[slot] = '0;
               if (hi_width[slot] < mcdew_pkg::MAX_WIDTH_DEF)
                  hi_width[slot]++;
               if (hi_conf[slot] < filt)
                  hi_conf[slot]++;
               else if (!lvl[slot]) begin
                  lo_conf[slot]   = '0;
                  lvl[slot]       = 1'b1;
                  rise_flag[slot] = 1'b1;
               end
            end else begin
               if (lo_conf[slot] == 0)
                  lo_width[slot] = '0;
               if (lo_width[slot] < mcdew_pkg::MAX_WIDTH_DEF)
                  lo_width[slot]++;
               if (lo_conf[slot] < filt)
                  lo_conf[slot]++;
               else if (lvl[slot]) begin
                  hi_conf[slot]   = '0;
                  lvl[slot]       = 1'b0;
                  fall_flag[slot] = 1'b1;
               end
            end
         end
      end
   endfunction

   // Work out the response of a group or channel read and clear its flags.
   function automatic void take_status_read(input logic [mcdew_pkg::FUNC_BITS-1:0] func,
                                            input logic [mcdew_pkg::GROUP_BITS-1:0] grp,
                                            input logic [mcdew_pkg::CHANNEL_BITS-1:0] chn);
      mcdew_pkg::rsp_word_type w;
      int base;
      int slot;
      w    = '0;
      base = int'(grp) * mcdew_pkg::SLOT_STRIDE;
      slot = base + int'(chn);
      if (grp < mcdew_pkg::NUM_GROUPS_DEF) begin
         if (func == mcdew_pkg::FUNC_READ_GROUP) begin
            w.level_bits   = lvl[base +: mcdew_pkg::SLOT_STRIDE];
            w.rising_bits  = rise_flag[base +: mcdew_pkg::SLOT_STRIDE];
            w.falling_bits = fall_flag[base +: mcdew_pkg::SLOT_STRIDE];
            rise_flag[base +: mcdew_pkg::SLOT_STRIDE] = '0;
            fall_flag[base +: mcdew_pkg::SLOT_STRIDE] = '0;
         end else if (chn < mcdew_pkg::CHANNELS_PER_GROUP_DEF) begin
            w.level_bits   = 8'(lvl[slot]);
            w.rising_bits  = 8'(rise_flag[slot]);
            w.falling_bits = 8'(fall_flag[slot]);
            w.high_width   = hi_width[slot];
            w.low_width    = lo_width[slot];
            rise_flag[slot] = 1'b0;
            fall_flag[slot] = 1'b0;
         end
      end
      pending_status.push_back(w);
   endfunction

   // Offer one request word, hold it until accepted, then advance the predictor.
   // Valid is left high so that a following word can go out without a gap.
   task automatic send_word(input logic [mcdew_pkg::FUNC_BITS-1:0] func,
                            input logic [mcdew_pkg::RAW_BITS-1:0] raw,
                            input logic [mcdew_pkg::GROUP_BITS-1:0] grp,
                            input logic [mcdew_pkg::CHANNEL_BITS-1:0] chn);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= func;
      req_chan.raw_levels <= raw;
      req_chan.group      <= grp;
      req_chan.channel    <= chn;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      case (func)
         mcdew_pkg::FUNC_SAMPLE:
            debounce_tick(raw);
         mcdew_pkg::FUNC_READ_GROUP, mcdew_pkg::FUNC_READ_CHANNEL:
            take_status_read(func, grp, chn);
         default: ;
      endcase
   endtask

   // Drop valid, wait for every owed response, then let the block settle.
   task automatic wait_reads_done();
      int waited;
      req_chan.valid <= 1'b0;
      waited = 0;
      while (pending_status.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_status.size() != 0) begin
         $error("%0d response words never arrived", pending_status.size());
         mismatch_count++;
         pending_status.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; only called with the block idle.
   task automatic write_reg(input logic [mcdew_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [mcdew_pkg::CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      set_register(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Reset contents, out-of-range reads, the ignored code, and a first
   // rise and fall at the reset filter time.
   task automatic test_reset_and_ranges();
      send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'd0, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_GROUP, '1, 3'd7, 3'd7);
      send_word(mcdew_pkg::FUNC_READ_CHANNEL, '0, 3'd6, 3'd7);
      send_word(mcdew_pkg::FUNC_READ_CHANNEL, '0, 3'd5, 3'd0);
      send_word(FUNC_UNUSED, '1, 3'd7, 3'd7);
      repeat (6) send_word(mcdew_pkg::FUNC_SAMPLE, '1, 3'd0, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'd1, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'd0, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_CHANNEL, '0, 3'd0, 3'd1);
      send_word(mcdew_pkg::FUNC_READ_CHANNEL, '0, 3'd0, 3'd7);
      repeat (6) send_word(mcdew_pkg::FUNC_SAMPLE, '0, 3'd0, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'd5, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_CHANNEL, '0, 3'd1, 3'd7);
      send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'd3, 3'd0);
      send_word(mcdew_pkg::FUNC_SAMPLE, 48'hAAAA_AAAA_AAAA, 3'd0, 3'd0);
      wait_reads_done();
   endtask

   // Filter time at both ends, and lowered beneath a running confirm count.
   task automatic test_filter_limits();
      write_reg(mcdew_pkg::CSR_FILTER_TIME, 8'd0);
      send_word(mcdew_pkg::FUNC_SAMPLE, 48'h5555_5555_5555, 3'd0, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'd0, 3'd0);
      send_word(mcdew_pkg::FUNC_SAMPLE, 48'hAAAA_AAAA_AAAA, 3'd0, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'd1, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_CHANNEL, '0, 3'd4, 3'd5);
      wait_reads_done();
      write_reg(mcdew_pkg::CSR_FILTER_TIME, 8'd255);
      repeat (257) send_word(mcdew_pkg::FUNC_SAMPLE, '1, 3'd0, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'd2, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_CHANNEL, '0, 3'd2, 3'd0);
      wait_reads_done();
      // Build up a low count, then drop the filter time below it.
      write_reg(mcdew_pkg::CSR_FILTER_TIME, 8'd40);
      repeat (20) send_word(mcdew_pkg::FUNC_SAMPLE, '0, 3'd0, 3'd0);
      wait_reads_done();
      write_reg(mcdew_pkg::CSR_FILTER_TIME, 8'd3);
      send_word(mcdew_pkg::FUNC_SAMPLE, '0, 3'd0, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'd2, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'd4, 3'd0);
      wait_reads_done();
   endtask

   // Channel counts (zero, saturated, upper data bits set), disabled groups,
   // and stale flags left on channels that fell out of use.
   task automatic test_channel_counts();
      write_reg(mcdew_pkg::CSR_FILTER_TIME, 8'd1);
      write_reg(mcdew_pkg::CSR_GROUP_ENABLE, 8'b1101_0111);
      write_reg(mcdew_pkg::CSR_GROUP0_CHANNELS, 8'd15);
      write_reg(mcdew_pkg::CSR_GROUP0_CHANNELS + 3'd1, 8'd0);
      write_reg(mcdew_pkg::CSR_GROUP0_CHANNELS + 3'd2, 8'hF3);
      write_reg(mcdew_pkg::CSR_GROUP0_CHANNELS + 3'd3, 8'd6);
      write_reg(mcdew_pkg::CSR_GROUP0_CHANNELS + 3'd4, 8'd1);
      write_reg(mcdew_pkg::CSR_GROUP5_CHANNELS, 8'd8);
      repeat (3) send_word(mcdew_pkg::FUNC_SAMPLE, '1, 3'd0, 3'd0);
      for (int g = 0; g < mcdew_pkg::NUM_GROUPS_DEF; g++)
         send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'(g), 3'd0);
      wait_reads_done();
      // Raise flags in group 3, then take its channels out of use.
      write_reg(mcdew_pkg::CSR_GROUP_ENABLE, 8'h3F);
      repeat (3) send_word(mcdew_pkg::FUNC_SAMPLE, '0, 3'd0, 3'd0);
      repeat (3) send_word(mcdew_pkg::FUNC_SAMPLE, '1, 3'd0, 3'd0);
      wait_reads_done();
      write_reg(mcdew_pkg::CSR_GROUP0_CHANNELS + 3'd3, 8'd0);
      send_word(mcdew_pkg::FUNC_READ_CHANNEL, '0, 3'd3, 3'd5);
      send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'd3, 3'd0);
      repeat (3) send_word(mcdew_pkg::FUNC_SAMPLE, '0, 3'd0, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_CHANNEL, '0, 3'd3, 3'd2);
      wait_reads_done();
      // Every group disabled: samples must leave all state untouched.
      write_reg(mcdew_pkg::CSR_GROUP_ENABLE, 8'd0);
      repeat (5) send_word(mcdew_pkg::FUNC_SAMPLE, rand48(), 3'd0, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'd1, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_CHANNEL, '0, 3'd5, 3'd3);
      wait_reads_done();
   endtask

   // Pick a fresh register set: mostly small filter times so that levels
   // actually flip, with the extremes mixed in.
   task automatic pick_random_settings();
      int r;
      wait_reads_done();
      r = $urandom_range(9);
      write_reg(mcdew_pkg::CSR_FILTER_TIME, (r == 0) ? 8'd0 : (r == 1) ? 8'd255
                                            : 8'($urandom_range(1, 6)));
      write_reg(mcdew_pkg::CSR_GROUP_ENABLE,
                ($urandom_range(3) == 0) ? 8'($urandom_range(63)) : 8'h3F);
      for (int g = 0; g < mcdew_pkg::REG_GROUPS; g++)
         write_reg(mcdew_pkg::CSR_GROUP0_CHANNELS + 3'(g),
                   ($urandom_range(3) == 0) ? 8'($urandom) : 8'd8);
   endtask

   // Bouncing inputs around a settled pattern that moves now and then,
   // interleaved with group and channel reads.
   task automatic run_random_block(input int items);
      logic [mcdew_pkg::RAW_BITS-1:0] settled;
      logic [mcdew_pkg::RAW_BITS-1:0] raw;
      int r;
      settled = rand48();
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(99);
         if (r < 5)
            settled = settled ^ rand48();
         if (r == 0)
            wait_reads_done();
         if (r < 62) begin
            raw = settled;
            // Sparse bounce on a few bits.
            if ($urandom_range(3) == 0)
               raw = raw ^ (rand48() & rand48() & rand48());
            send_word(mcdew_pkg::FUNC_SAMPLE, raw, 3'($urandom), 3'($urandom));
         end else if (r < 97) begin
            send_word((r < 80) ? mcdew_pkg::FUNC_READ_GROUP : mcdew_pkg::FUNC_READ_CHANNEL,
                      rand48(),
                      ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                               : 3'($urandom_range(5)),
                      3'($urandom));
         end else begin
            send_word(FUNC_UNUSED, rand48(), 3'($urandom), 3'($urandom));
         end
      end
   endtask

   // Three idling modes in turn: receiver-heavy, sender-heavy, none.
   task automatic test_random_traffic();
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 22 : (p == 1) ? 55 : 0;
         recv_idle_pct = (p == 0) ? 55 : (p == 1) ? 22 : 0;
         for (int b = 0; b < 3; b++) begin
            pick_random_settings();
            run_random_block(95);
         end
      end
      wait_reads_done();
   endtask

   // Hold group 1 high and group 2 low for a long run and read both widths.
   task automatic test_width_hold();
      write_reg(mcdew_pkg::CSR_FILTER_TIME, mcdew_pkg::FILTER_TIME_RST);
      write_reg(mcdew_pkg::CSR_GROUP_ENABLE, 8'h3F);
      write_reg(mcdew_pkg::CSR_GROUP0_CHANNELS + 3'd1, 8'd8);
      write_reg(mcdew_pkg::CSR_GROUP0_CHANNELS + 3'd2, 8'd8);
      for (int i = 0; i < HOLD_SAMPLES; i++)
         send_word(mcdew_pkg::FUNC_SAMPLE, 48'h0000_0000_FF00, 3'd0, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_CHANNEL, '0, 3'd1, 3'd0);
      send_word(mcdew_pkg::FUNC_READ_CHANNEL, '0, 3'd2, 3'd7);
      send_word(mcdew_pkg::FUNC_READ_GROUP, '0, 3'd1, 3'd0);
      wait_reads_done();
   endtask

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Response side: stall at random and check each word taken against the
   // oldest owed word.
   initial begin : rsp_side
      mcdew_pkg::rsp_word_type want;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (pending_status.size() == 0) begin
               $error("response word arrived with none owed");
               mismatch_count++;
            end else begin
               want = pending_status.pop_front();
               compare_field("level_bits", 16'(want.level_bits),
                             16'(rsp_chan.level_bits));
               compare_field("rising_bits", 16'(want.rising_bits),
                             16'(rsp_chan.rising_bits));
               compare_field("falling_bits", 16'(want.falling_bits),
                             16'(rsp_chan.falling_bits));
               compare_field("high_width", want.high_width, rsp_chan.high_width);
               compare_field("low_width", want.low_width, rsp_chan.low_width);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Sequence: hold reset, run each test in turn, settle and report.
   initial begin
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.func       <= mcdew_pkg::FUNC_SAMPLE;
      req_chan.raw_levels <= '0;
      req_chan.group      <= '0;
      req_chan.channel    <= '0;
      clear_debounce_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_and_ranges();
      test_filter_limits();
      test_channel_counts();
      test_random_traffic();
      test_width_hold();
      wait_reads_done();
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/mcdew_pkg.sv
rtl/core/mcdew_if.sv
rtl/core/mcdew_lane.sv
rtl/core/mcdew_merge.sv
rtl/core/multi_channel_debounce_edge_width_core.sv
rtl/core/mcdew_checker.sv
sim/tb_top.sv
